// File: rtl/pfhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the port filtered header capture block.
// No dependencies; used by the top level, the parser, the queue and the testbench.
package pfhc_pkg;

  localparam int MAX_PORTS_DEF   = 8;
  localparam int MAX_CAPTURE_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] POS_TYPE_HI    = 16'd12;
  localparam logic [15:0] POS_TYPE_LO    = 16'd13;
  localparam logic [15:0] POS_IHL        = 16'd14;
  localparam logic [15:0] POS_PROTO      = 16'd23;
  localparam logic [15:0] POS_L4_MIN     = 16'd24;
  localparam logic [15:0] IP_HDR_START   = 16'd14;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [6:0]  CAP_LEN_RESET  = 7'd16;

  localparam logic [1:0] REG_PORT_COUNT  = 2'd0;
  localparam logic [1:0] REG_PORTS_FIRST = 2'd1;
  localparam logic [1:0] REG_PORTS_LAST  = 2'd2;
  localparam logic [1:0] REG_CAP_LEN     = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_PARSING,
    VERDICT_DROPPED,
    VERDICT_CAPTURING
  } verdict_t;

  typedef struct packed {
    logic        all_captured;
    logic        capture_last;
    logic        is_udp;
    logic [5:0]  byte_index;
    logic [15:0] source_port;
    logic [7:0]  kept_byte;
  } result_t;

  // one queue entry holds the results of one input beat
  typedef struct packed {
    logic    two;
    result_t res1;
    result_t res0;
  } entry_t;

endpackage

// File: rtl/port_filtered_header_capture.sv
`timescale 1ns / 1ps
// Top level: configuration registers, frame parser and result queue.
// Depends on pfhc_pkg, pfhc_parser and pfhc_queue.

// Takes one frame byte per cycle with no gaps required. Each byte is parsed in the cycle it is
// accepted and its results land in a four-entry queue; a byte gives at most one output beat,
// except the second source-port byte of a newly matched port, which gives two unless the
// capture length is zero or one. With the output side always ready the block sustains one byte
// per cycle; s_axis_tready drops only while the queue holds four entries. Captured flags clear
// at reset only; configuration is always ready.
module port_filtered_header_capture import pfhc_pkg::*; #(
  parameter int MAX_PORTS   = MAX_PORTS_DEF,
  parameter int MAX_CAPTURE = MAX_CAPTURE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // frame_byte
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // kept_byte, source_port, byte_index, zero pad
  output logic        m_axis_tlast,   // capture_last
  output logic [1:0]  m_axis_tuser,   // is_udp, all_captured
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [3:0]                port_count;
  logic [63:0]               ports_first_four;
  logic [63:0]               ports_last_four;
  logic [6:0]                capture_length;
  logic [MAX_PORTS-1:0][15:0] ports;
  logic                      in_acc;
  logic                      push;
  entry_t                    push_entry;
  logic                      space;
  result_t                   out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count       <= '0;
      ports_first_four <= '0;
      ports_last_four  <= '0;
      capture_length   <= CAP_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PORT_COUNT:  port_count       <= cfg_data[3:0];
        REG_PORTS_FIRST: ports_first_four <= cfg_data;
        REG_PORTS_LAST:  ports_last_four  <= cfg_data;
        REG_CAP_LEN:     capture_length   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_PORTS; i++) begin : g_ports
    if (i < 4) begin : g_lo
      assign ports[i] = ports_first_four[16*i +: 16];
    end else begin : g_hi
      assign ports[i] = ports_last_four[16*(i-4) +: 16];
    end
  end

  assign s_axis_tready = space;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  pfhc_parser #(
    .MAX_PORTS   (MAX_PORTS),
    .MAX_CAPTURE (MAX_CAPTURE)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_acc),
    .in_byte        (s_axis_tdata),
    .in_end         (s_axis_tlast),
    .port_count     (port_count),
    .ports          (ports),
    .capture_length (capture_length),
    .push           (push),
    .push_entry     (push_entry)
  );

  pfhc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .space      (space),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.byte_index, out_res.source_port, out_res.kept_byte};
  assign m_axis_tlast = out_res.capture_last;
  assign m_axis_tuser = {out_res.all_captured, out_res.is_udp};

endmodule

// File: rtl/pfhc_parser.sv
`timescale 1ns / 1ps
// Frame parser: header checks, source port match, captured flags and result build.
// Depends on pfhc_pkg.
module pfhc_parser import pfhc_pkg::*; #(
  parameter int MAX_PORTS   = MAX_PORTS_DEF,
  parameter int MAX_CAPTURE = MAX_CAPTURE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [7:0]                in_byte,
  input  logic                      in_end,
  input  logic [3:0]                port_count,
  input  logic [MAX_PORTS-1:0][15:0] ports,
  input  logic [6:0]                capture_length,
  output logic                      push,
  output entry_t                    push_entry
);

  localparam int CNT_W = $clog2(MAX_CAPTURE + 1);
  localparam int LW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int IDX_W = (CNT_W < 6) ? CNT_W : 6;

  logic [15:0]          pos, pos_next;
  verdict_t             verdict, verdict_next;
  logic [7:0]           type_hi, type_hi_next;
  logic [3:0]           hw, hw_next;
  logic                 udp, udp_next;
  logic [7:0]           held, held_next;
  logic [15:0]          mport, mport_next;
  logic [CNT_W-1:0]     emitted, emitted_next;
  logic [MAX_PORTS-1:0] captured, captured_next;

  logic [3:0]           vcnt;
  logic [LW-1:0]        clen_ext;
  logic [CNT_W-1:0]     eff_len;
  logic [15:0]          start;
  logic [15:0]          cur_port;
  logic [MAX_PORTS-1:0] hit;
  logic                 found;
  logic                 new_cap;
  logic                 at_match;
  logic                 do_match;
  logic                 do_cap;
  logic                 all_done;

  always_comb begin
    vcnt = (port_count > 4'(MAX_PORTS)) ? 4'(MAX_PORTS) : port_count;
    clen_ext = LW'(capture_length);
    if (capture_length == 7'd0) begin
      eff_len = CNT_W'(1);
    end else if (clen_ext > LW'(MAX_CAPTURE)) begin
      eff_len = CNT_W'(MAX_CAPTURE);
    end else begin
      eff_len = CNT_W'(clen_ext);
    end
  end

  assign start    = IP_HDR_START + {10'd0, hw, 2'b00};
  assign cur_port = {held, in_byte};

  // lowest matching entry wins
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_PORTS; i++) begin
      if (!found && (4'(i) < vcnt) && (ports[i] == cur_port)) begin
        hit[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  assign new_cap  = found && ((hit & captured) == '0);
  assign at_match = (verdict == VERDICT_PARSING) && (pos >= POS_L4_MIN)
                    && (pos == start + 16'd1);
  assign do_match = in_valid && at_match && new_cap;
  assign do_cap   = in_valid && (verdict == VERDICT_CAPTURING) && (emitted < eff_len);

  always_comb begin
    pos_next      = pos;
    verdict_next  = verdict;
    type_hi_next  = type_hi;
    hw_next       = hw;
    udp_next      = udp;
    held_next     = held;
    mport_next    = mport;
    emitted_next  = emitted;
    captured_next = captured;
    if (in_valid) begin
      case (verdict)
        VERDICT_PARSING: begin
          if (pos == POS_TYPE_HI) begin
            type_hi_next = in_byte;
          end else if (pos == POS_TYPE_LO) begin
            if ({type_hi, in_byte} != ETHERTYPE_IPV4) verdict_next = VERDICT_DROPPED;
          end else if (pos == POS_IHL) begin
            hw_next = in_byte[3:0];
            if (in_byte[3:0] < IHL_MIN) verdict_next = VERDICT_DROPPED;
          end else if (pos == POS_PROTO) begin
            if (in_byte == PROTO_TCP) begin
              udp_next = 1'b0;
            end else if (in_byte == PROTO_UDP) begin
              udp_next = 1'b1;
            end else begin
              verdict_next = VERDICT_DROPPED;
            end
          end else if (pos >= POS_L4_MIN && pos == start) begin
            held_next = in_byte;
          end else if (at_match) begin
            if (new_cap) begin
              captured_next = captured | hit;
              mport_next    = cur_port;
              emitted_next  = (eff_len == CNT_W'(1)) ? CNT_W'(1) : CNT_W'(2);
              verdict_next  = (eff_len <= CNT_W'(2)) ? VERDICT_DROPPED : VERDICT_CAPTURING;
            end else begin
              verdict_next = VERDICT_DROPPED;
            end
          end
        end
        VERDICT_CAPTURING: begin
          if (do_cap) begin
            emitted_next = emitted + CNT_W'(1);
            if ((CNT_W + 1)'(emitted) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(eff_len)) begin
              verdict_next = VERDICT_DROPPED;
            end
          end else begin
            verdict_next = VERDICT_DROPPED;
          end
        end
        default: ;
      endcase
      if (in_end) begin
        pos_next     = '0;
        verdict_next = VERDICT_PARSING;
        emitted_next = '0;
      end else if (pos != 16'hFFFF) begin
        pos_next = pos + 16'd1;
      end
    end
  end

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < MAX_PORTS; i++) begin
      if ((4'(i) < vcnt) && !captured_next[i]) all_done = 1'b0;
    end
  end

  always_comb begin
    push_entry = '0;
    push       = do_match || do_cap;
    if (do_match) begin
      push_entry.two                   = (eff_len != CNT_W'(1));
      push_entry.res0.kept_byte        = held;
      push_entry.res0.source_port      = cur_port;
      push_entry.res0.byte_index       = 6'd0;
      push_entry.res0.is_udp           = udp;
      push_entry.res0.capture_last     = (eff_len == CNT_W'(1));
      push_entry.res0.all_captured     = all_done;
      push_entry.res1.kept_byte        = in_byte;
      push_entry.res1.source_port      = cur_port;
      push_entry.res1.byte_index       = 6'd1;
      push_entry.res1.is_udp           = udp;
      push_entry.res1.capture_last     = (eff_len <= CNT_W'(2)) || in_end;
      push_entry.res1.all_captured     = all_done;
    end else begin
      push_entry.two                   = 1'b0;
      push_entry.res0.kept_byte        = in_byte;
      push_entry.res0.source_port      = mport;
      push_entry.res0.byte_index       = 6'(emitted[IDX_W-1:0]);
      push_entry.res0.is_udp           = udp;
      push_entry.res0.capture_last     =
        ((CNT_W + 1)'(emitted) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(eff_len)) || in_end;
      push_entry.res0.all_captured     = all_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      verdict  <= VERDICT_PARSING;
      type_hi  <= '0;
      hw       <= '0;
      udp      <= 1'b0;
      held     <= '0;
      mport    <= '0;
      emitted  <= '0;
      captured <= '0;
    end else begin
      pos      <= pos_next;
      verdict  <= verdict_next;
      type_hi  <= type_hi_next;
      hw       <= hw_next;
      udp      <= udp_next;
      held     <= held_next;
      mport    <= mport_next;
      emitted  <= emitted_next;
      captured <= captured_next;
    end
  end

endmodule

// File: rtl/pfhc_queue.sv
`timescale 1ns / 1ps
// Result queue: one entry per input beat that yields results, each entry gives one or two output beats.
// Depends on pfhc_pkg.
module pfhc_queue import pfhc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            sub;
  logic            beat;
  logic            pop;
  entry_t          head;

  assign head      = mem[rd_ptr];
  assign out_valid = (count != '0);
  assign out_res   = sub ? head.res1 : head.res0;
  assign space     = (count < (PW + 1)'(QUEUE_DEPTH));
  assign beat      = out_valid && out_ready;
  assign pop       = beat && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) begin
        count <= count + (PW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW + 1)'(1);
      end
      if (beat) sub <= !pop;
    end
  end

endmodule

// File: rtl/pfhc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for port_filtered_header_capture, attached by bind.
// Depends only on the top level's ports.
module pfhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // input backpressure only comes from a full queue
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // reset empties the queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("queue not empty after reset");

  // pad bits of tdata stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
    else $error("tdata pad bits set");

endmodule

bind port_filtered_header_capture pfhc_checker u_pfhc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/port_filtered_header_capture_tb.sv
`timescale 1ns / 1ps
// Testbench for port_filtered_header_capture: streams Ethernet frames through the block
// and checks every captured transport byte against a byte-level filter predictor.
// Depends on pfhc_pkg and the RTL of the block; reads no files.
module port_filtered_header_capture_tb;
  import pfhc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_PORT_COUNT;
  logic [63:0] cfg_data = 64'd0;

  // register shadows
  logic [3:0]  port_count_cfg = 4'd0;
  logic [63:0] ports_lo_cfg = 64'd0;
  logic [63:0] ports_hi_cfg = 64'd0;
  logic [6:0]  capture_len_cfg = CAP_LEN_RESET;

  // filter state as of the last accepted beat
  logic [15:0] byte_pos = 16'd0;
  verdict_t    frame_state = VERDICT_PARSING;
  logic [7:0]  type_hi = 8'd0;
  logic [3:0]  hdr_words = 4'd0;
  logic        frame_udp = 1'b0;
  logic [7:0]  port_hi = 8'd0;
  logic [15:0] cur_port = 16'd0;
  logic [6:0]  bytes_kept = 7'd0;
  logic [7:0]  entry_done = 8'd0;

  frame_beat_t pending_beats[$];
  result_t     expected_captures[$];

  int beats_queued = 0;
  int beats_accepted = 0;
  int frames_queued = 0;
  int settings_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int lost_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  rx_pattern_t rx_pattern = RX_STEADY;

  port_filtered_header_capture uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int active_ports();
    return (port_count_cfg > MAX_PORTS_DEF) ? MAX_PORTS_DEF : int'(port_count_cfg);
  endfunction

  function automatic int kept_length();
    if (capture_len_cfg == 7'd0) return 1;
    if (capture_len_cfg > MAX_CAPTURE_DEF) return MAX_CAPTURE_DEF;
    return int'(capture_len_cfg);
  endfunction

  function automatic logic [15:0] entry_port(int i);
    return (i < 4) ? ports_lo_cfg[16*i +: 16] : ports_hi_cfg[16*(i-4) +: 16];
  endfunction

  function automatic int l4_start(logic [7:0] ihl_byte);
    return int'(IP_HDR_START) + 4 * int'(ihl_byte[3:0]);
  endfunction

  function automatic logic all_ports_done();
    int i;
    for (i = 0; i < active_ports(); i++)
      if (!entry_done[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void keep_byte(logic [7:0] b, logic fin);
    result_t r;
    int len;
    len = kept_length();
    r.kept_byte = b;
    r.source_port = cur_port;
    r.byte_index = bytes_kept[5:0];
    r.is_udp = frame_udp;
    r.capture_last = (int'(bytes_kept) + 1 >= len) || fin;
    r.all_captured = all_ports_done();
    expected_captures.insert(expected_captures.size(), r);
    bytes_kept++;
    if (int'(bytes_kept) >= len) frame_state = VERDICT_DROPPED;
  endfunction

  function automatic void clear_frame();
    byte_pos = 16'd0;
    frame_state = VERDICT_PARSING;
    type_hi = 8'd0;
    hdr_words = 4'd0;
    frame_udp = 1'b0;
    port_hi = 8'd0;
    cur_port = 16'd0;
    bytes_kept = 7'd0;
  endfunction

  // advance the filter by one frame byte, queueing the captured bytes it yields
  function automatic void filter_frame_byte(logic [7:0] b, logic fin);
    int start;
    int hit;
    int i;
    logic [15:0] port;
    start = int'(IP_HDR_START) + 4 * int'(hdr_words);
    if (frame_state == VERDICT_PARSING) begin
      if (byte_pos == POS_TYPE_HI) begin
        type_hi = b;
      end else if (byte_pos == POS_TYPE_LO) begin
        if ({type_hi, b} != ETHERTYPE_IPV4) frame_state = VERDICT_DROPPED;
      end else if (byte_pos == POS_IHL) begin
        hdr_words = b[3:0];
        if (hdr_words < IHL_MIN) frame_state = VERDICT_DROPPED;
      end else if (byte_pos == POS_PROTO) begin
        if (b == PROTO_TCP) frame_udp = 1'b0;
        else if (b == PROTO_UDP) frame_udp = 1'b1;
        else frame_state = VERDICT_DROPPED;
      end else if (byte_pos >= POS_L4_MIN && byte_pos == start) begin
        port_hi = b;
      end else if (byte_pos >= POS_L4_MIN && byte_pos == start + 1) begin
        port = {port_hi, b};
        hit = -1;
        for (i = 0; i < active_ports(); i++)
          if (hit < 0 && entry_port(i) == port) hit = i;
        if (hit < 0 || entry_done[hit]) begin
          frame_state = VERDICT_DROPPED;
        end else begin
          cur_port = port;
          entry_done[hit] = 1'b1;
          bytes_kept = 7'd0;
          frame_state = VERDICT_CAPTURING;
          keep_byte(port_hi, 1'b0);
          if (frame_state == VERDICT_CAPTURING) keep_byte(b, fin);
        end
      end
    end else if (frame_state == VERDICT_CAPTURING) begin
      if (int'(bytes_kept) < kept_length()) keep_byte(b, fin);
      else frame_state = VERDICT_DROPPED;
    end
    if (fin) clear_frame();
    else if (byte_pos != 16'hFFFF) byte_pos++;
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    frame_beat_t nb;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filter_frame_byte(s_axis_tdata, s_axis_tlast);
        beats_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          nb = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nb.data;
          s_axis_tlast <= nb.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: checks each output beat, stalls on a pattern that changes now and then
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kept_byte = m_axis_tdata[7:0];
        got.source_port = m_axis_tdata[23:8];
        got.byte_index = m_axis_tdata[29:24];
        got.is_udp = m_axis_tuser[0];
        got.all_captured = m_axis_tuser[1];
        got.capture_last = m_axis_tlast;
        if (expected_captures.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected beat byte %h port %h index %0d", $time,
                     got.kept_byte, got.source_port, got.byte_index);
        end else begin
          want = expected_captures.pop_front();
          checked_count++;
          if (got.kept_byte !== want.kept_byte || got.source_port !== want.source_port ||
              got.byte_index !== want.byte_index || got.is_udp !== want.is_udp ||
              got.capture_last !== want.capture_last ||
              got.all_captured !== want.all_captured) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected byte %h port %h index %0d udp %b last %b all %b,",
                       $time, want.kept_byte, want.source_port, want.byte_index,
                       want.is_udp, want.capture_last, want.all_captured,
                       " got byte %h port %h index %0d udp %b last %b all %b",
                       got.kept_byte, got.source_port, got.byte_index, got.is_udp,
                       got.capture_last, got.all_captured);
          end
        end
      end
      if (stall_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 2));
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (rx_pattern)
        RX_STEADY: m_axis_tready <= 1'b1;
        RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 1) == 1);
        default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PORT_COUNT:  port_count_cfg = value[3:0];
      REG_PORTS_FIRST: ports_lo_cfg = value;
      REG_PORTS_LAST:  ports_hi_cfg = value;
      REG_CAP_LEN:     capture_len_cfg = value[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] cnt, input logic [63:0] lo, input logic [63:0] hi,
                           input logic [6:0] len);
    write_register(REG_PORT_COUNT, {60'd0, cnt});
    write_register(REG_PORTS_FIRST, lo);
    write_register(REG_PORTS_LAST, hi);
    write_register(REG_CAP_LEN, {57'd0, len});
    settings_count++;
  endtask

  // holds off until every beat is in and every captured byte is out, or counts the missing ones as lost
  task automatic wait_for_drain();
    int guard;
    guard = 0;
    while (beats_accepted != beats_queued) @(posedge clk);
    while (expected_captures.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_captures.size() != 0) begin
      lost_count += expected_captures.size();
      $display("%0t: %0d captured bytes never arrived", $time, expected_captures.size());
      expected_captures.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_frame(input logic [15:0] etype, input logic [7:0] ihl_byte,
                             input logic [7:0] proto, input logic [15:0] sport, input int len);
    int start;
    int p;
    frame_beat_t beat;
    start = l4_start(ihl_byte);
    for (p = 0; p < len; p++) begin
      beat.data = 8'($urandom);
      if (p == POS_TYPE_HI) beat.data = etype[15:8];
      else if (p == POS_TYPE_LO) beat.data = etype[7:0];
      else if (p == POS_IHL) beat.data = ihl_byte;
      else if (p == POS_PROTO) beat.data = proto;
      else if (p == start) beat.data = sport[15:8];
      else if (p == start + 1) beat.data = sport[7:0];
      beat.last = (p == len - 1);
      pending_beats.insert(pending_beats.size(), beat);
    end
    beats_queued += len;
    frames_queued++;
  endtask

  task automatic random_setting();
    logic [3:0] cnt;
    logic [6:0] len;
    cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(7, 15));
    case ($urandom_range(0, 9))
      0:       len = 7'd0;
      1:       len = 7'($urandom_range(65, 127));
      2:       len = 7'd64;
      default: len = 7'($urandom_range(1, 64));
    endcase
    configure(cnt, {$urandom, $urandom}, {$urandom, $urandom}, len);
  endtask

  // mostly well-formed frames aimed at configured ports, the rest broken or noise
  task automatic random_frame();
    logic [15:0] etype;
    logic [15:0] sport;
    logic [7:0]  ihl_byte;
    logic [7:0]  proto;
    int len;
    int kind;
    kind = $urandom_range(0, 99);
    etype = ETHERTYPE_IPV4;
    ihl_byte = {4'($urandom_range(0, 15)), 4'($urandom_range(5, 15))};
    proto = ($urandom_range(0, 1) == 1) ? PROTO_UDP : PROTO_TCP;
    sport = ($urandom_range(0, 9) < 7) ? entry_port($urandom_range(0, 7)) : 16'($urandom);
    len = l4_start(ihl_byte) + 2 + $urandom_range(0, 70);
    if (kind >= 95) begin
      etype = 16'($urandom);
      len = $urandom_range(1, 40);
    end else if (kind >= 88) begin
      proto = 8'($urandom);
    end else if (kind >= 81) begin
      ihl_byte[3:0] = 4'($urandom_range(0, 4));
    end else if (kind >= 73) begin
      etype = 16'($urandom);
    end else if (kind >= 65) begin
      len = $urandom_range(1, l4_start(ihl_byte) + 1);
    end
    queue_frame(etype, ihl_byte, proto, sport, len);
  endtask

  initial begin
    int i;
    int n;
    int phase;
    int base_beats;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // no valid ports: a good frame gives nothing
    configure(4'd0, 64'h0000_0000_0000_1234, 64'hFFFF_FFFF_FFFF_FFFF, CAP_LEN_RESET);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'h1234, 40);
    wait_for_drain();

    // capture length 0 acts as 1; drops for type, IHL, protocol and short frames
    configure(4'd2, 64'h0000_0000_FFFF_0000, 64'd0, 7'd0);
    queue_frame(16'h86DD, 8'h45, PROTO_UDP, 16'h0000, 40);
    queue_frame(ETHERTYPE_IPV4, 8'h44, PROTO_UDP, 16'h0000, 40);
    queue_frame(ETHERTYPE_IPV4, 8'h45, 8'd1, 16'h0000, 40);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0000, 35);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0000, 20);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0000, 40);
    queue_frame(ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 16'hFFFF, 80);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0000, 40);
    wait_for_drain();

    // count above max, length above max, duplicate port, early ends
    configure(4'd15, 64'h0050_1F90_FFFF_0000, 64'h0035_ABCD_1F90_8000, 7'd127);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'h1F90, 100);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'h1F90, 40);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'h0050, 44);
    queue_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'h8000, 36);
    queue_frame(ETHERTYPE_IPV4, 8'h46, PROTO_UDP, 16'h0035, 68);
    wait_for_drain();

    base_beats = beats_queued;
    phase = 0;
    while (phase < 40 && beats_queued - base_beats < 250) begin
      random_setting();
      n = $urandom_range(2, 4);
      for (i = 0; i < n; i++) random_frame();
      wait_for_drain();
      phase++;
    end
    repeat (16) @(posedge clk);

    $display("Ran %0d frames (%0d bytes) under %0d register settings, %0d bytes captured.",
             frames_queued, beats_accepted, settings_count, checked_count);
    $display("Entries captured %b, mismatches %0d, missing bytes %0d.",
             entry_done, mismatch_count, lost_count);
    if (mismatch_count == 0 && lost_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
